### rtl/nmea_gga_rmc_position_parser_defines.svh
// Assertion helpers for the NMEA position parser.
`ifndef NMEA_GGA_RMC_POSITION_PARSER_DEFINES_SVH
`define NMEA_GGA_RMC_POSITION_PARSER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define NMEA_PP_CHECK(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("nmea position parser: invariant violated");

// Cause in one cycle implies effect in the next.
`define NMEA_PP_CHECK_NEXT(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("nmea position parser: sequence violated");

`endif

### rtl/nmea_pp_pkg.sv
`default_nettype none
package nmea_pp_pkg;

   localparam int BUFFER_BYTES_DEF = 512;
   localparam int TOKEN_CHARS_DEF  = 16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_W     = 8'h57;

   localparam logic [9:0] GAP_RESET = 10'd50;

   localparam logic [39:0] DEG_CAP = 40'd999;
   localparam logic [39:0] MIN_CAP = 40'd999999999999;
   localparam logic [39:0] ALT_CAP = 40'd99999999;
   localparam logic [39:0] SPD_CAP = 40'd9999999;

   localparam logic [2:0] F_DEG = 3'd0;
   localparam logic [2:0] F_MIN = 3'd6;
   localparam logic [2:0] F_MM  = 3'd3;

   localparam logic signed [40:0] COORD_LIMIT = 41'sd10016666666;

   typedef enum logic [1:0] {PH_LEAD, PH_INT, PH_FRAC, PH_STOP} acc_phase_type;

   typedef struct packed {
      acc_phase_type phase;
      logic [2:0]    fdig;
      logic          neg;
      logic [39:0]   mag;
   } acc_type;

   localparam acc_type ACC_CLEAR = '{phase: PH_LEAD, fdig: 3'd0, neg: 1'b0, mag: 40'd0};

   typedef struct packed {
      logic    zero;
      acc_type deg;
      acc_type mins;
   } coord_raw_type;

   localparam coord_raw_type COORD_CLEAR = '{zero: 1'b1, deg: ACC_CLEAR, mins: ACC_CLEAR};

   typedef struct packed {
      logic          found;
      coord_raw_type lat;
      coord_raw_type lon;
      logic          south;
      logic          west;
      acc_type       alt;
      acc_type       spd;
   } snap_type;

   typedef struct packed {
      logic               found;
      logic signed [34:0] lat;
      logic signed [34:0] lon;
      logic signed [27:0] alt;
      logic signed [23:0] spd;
   } out_type;

   function automatic logic [19:0] pow10(input logic [2:0] e);
      case (e)
         3'd0: pow10 = 20'd1;
         3'd1: pow10 = 20'd10;
         3'd2: pow10 = 20'd100;
         3'd3: pow10 = 20'd1000;
         3'd4: pow10 = 20'd10000;
         3'd5: pow10 = 20'd100000;
         3'd6: pow10 = 20'd1000000;
         default: pow10 = 20'd0;
      endcase
   endfunction

   // Decimal accumulation: lead blanks, sign, integer, fraction, stop.
   function automatic acc_type acc_feed(input acc_type a, input logic [7:0] c,
                                        input logic [2:0] f, input logic [39:0] cap);
      acc_type     r;
      logic        is_dig;
      logic        is_space;
      logic        is_sign;
      logic [3:0]  d;
      logic [43:0] t;
      logic [2:0]  e;
      r        = a;
      d        = 4'(c - CH_ZERO);
      is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
      is_space = c inside {[8'd9:8'd13], CH_SPACE};
      is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
      e        = 3'(f - 3'd1 - a.fdig);
      t        = '0;
      case (a.phase)
         PH_LEAD, PH_INT: begin
            if (a.phase == PH_LEAD && is_sign) begin
               r.phase = PH_INT;
               r.neg   = (c == CH_MINUS);
            end else if (!(a.phase == PH_LEAD && is_space)) begin
               if (is_dig) begin
                  t       = 44'(a.mag) * 44'd10 + 44'(d) * 44'(pow10(f));
                  r.mag   = (t > 44'(cap)) ? cap : t[39:0];
                  r.phase = PH_INT;
               end else if (c == CH_DOT) begin
                  r.phase = PH_FRAC;
               end else begin
                  r.phase = PH_STOP;
               end
            end
         end
         PH_FRAC: begin
            if (is_dig) begin
               if (a.fdig < f) begin
                  t      = 44'(a.mag) + 44'(d) * 44'(pow10(e));
                  r.mag  = (t > 44'(cap)) ? cap : t[39:0];
                  r.fdig = 3'(a.fdig + 3'd1);
               end
            end else begin
               r.phase = PH_STOP;
            end
         end
         default: r = a;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/nmea_pp_scanner.sv
`default_nettype none
module nmea_pp_scanner #(
   parameter int BUFFER_BYTES = nmea_pp_pkg::BUFFER_BYTES_DEF,
   parameter int TOKEN_CHARS  = nmea_pp_pkg::TOKEN_CHARS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 cmd,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 csr_wr_en,
   input  wire logic [9:0]           csr_wr_data,
   output logic                      emit,
   output nmea_pp_pkg::snap_type     snap
);

   localparam int COUNT_W    = $clog2(BUFFER_BYTES);
   localparam int KEEP_CHARS = (TOKEN_CHARS < 31) ? TOKEN_CHARS : 31;
   localparam logic [9:0] IDLE_MAX = 10'd1023;
   localparam logic [2:0] TAG_LEN = 3'd7;
   localparam logic [3:0] GGA_LAT = 4'd2;
   localparam logic [3:0] GGA_NS  = 4'd3;
   localparam logic [3:0] GGA_LON = 4'd4;
   localparam logic [3:0] GGA_EW  = 4'd5;
   localparam logic [3:0] GGA_ALT = 4'd9;
   localparam logic [3:0] GGA_END = 4'd10;
   localparam logic [2:0] RMC_SPD = 3'd7;
   localparam logic [4:0] LEN_MAX = 5'd31;
   localparam logic [4:0] LEN_SHORT = 5'd5;
   localparam logic [4:0] DOT_POS = 5'd4;

   typedef struct packed {
      nmea_pp_pkg::acc_type deg;
      nmea_pp_pkg::acc_type mins;
   } cand_type;

   localparam cand_type CAND_CLEAR = '{deg: nmea_pp_pkg::ACC_CLEAR,
                                       mins: nmea_pp_pkg::ACC_CLEAR};

   logic [9:0]                 gap_ff, gap_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [9:0]                 idle_ff, idle_in;
   logic                       ended_ff, ended_in;
   logic [2:0]                 gga_prog_ff, gga_prog_in;
   logic [2:0]                 rmc_prog_ff, rmc_prog_in;
   logic [3:0]                 gga_field_ff, gga_field_in;
   logic [2:0]                 rmc_field_ff, rmc_field_in;
   logic [4:0]                 tok_len_ff, tok_len_in;
   logic                       dot4_ff, dot4_in;
   cand_type                   cand2_ff, cand2_in;
   cand_type                   cand3_ff, cand3_in;
   nmea_pp_pkg::coord_raw_type lat_ff, lat_in;
   nmea_pp_pkg::coord_raw_type lon_ff, lon_in;
   logic                       south_ff, south_in;
   logic                       west_ff, west_in;
   nmea_pp_pkg::acc_type       alt_ff, alt_in;
   nmea_pp_pkg::acc_type       spd_ff, spd_in;

   nmea_pp_pkg::coord_raw_type fin;
   logic [9:0]                 idle_next;
   logic [3:0]                 gga_step;
   logic [3:0]                 rmc_step;

   function automatic logic [7:0] tag_char(input logic rmc, input logic [2:0] idx);
      case (idx)
         3'd0: tag_char = nmea_pp_pkg::CH_DOLLAR;
         3'd1: tag_char = 8'h47;
         3'd2: tag_char = 8'h50;
         3'd3: tag_char = rmc ? 8'h52 : 8'h47;
         3'd4: tag_char = rmc ? 8'h4D : 8'h47;
         3'd5: tag_char = rmc ? 8'h43 : 8'h41;
         3'd6: tag_char = nmea_pp_pkg::CH_COMMA;
         default: tag_char = nmea_pp_pkg::CH_NUL;
      endcase
   endfunction

   // Returns {hit, next progress}.
   function automatic logic [3:0] tag_step(input logic [2:0] p, input logic rmc,
                                           input logic [7:0] c);
      if (p < TAG_LEN && c == tag_char(rmc, p)) begin
         if (p == 3'(TAG_LEN - 3'd1)) begin
            return {1'b1, 3'd0};
         end
         return {1'b0, 3'(p + 3'd1)};
      end
      return {1'b0, (c == nmea_pp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0};
   endfunction

   always_comb begin
      gap_in       = csr_wr_en ? csr_wr_data : gap_ff;
      count_in     = count_ff;
      idle_in      = idle_ff;
      ended_in     = ended_ff;
      gga_prog_in  = gga_prog_ff;
      rmc_prog_in  = rmc_prog_ff;
      gga_field_in = gga_field_ff;
      rmc_field_in = rmc_field_ff;
      tok_len_in   = tok_len_ff;
      dot4_in      = dot4_ff;
      cand2_in     = cand2_ff;
      cand3_in     = cand3_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      south_in     = south_ff;
      west_in      = west_ff;
      alt_in       = alt_ff;
      spd_in       = spd_ff;
      emit         = 1'b0;

      fin.zero  = (tok_len_ff <= LEN_SHORT);
      fin.deg   = dot4_ff ? cand2_ff.deg : cand3_ff.deg;
      fin.mins  = dot4_ff ? cand2_ff.mins : cand3_ff.mins;
      idle_next = (idle_ff == IDLE_MAX) ? idle_ff : 10'(idle_ff + 10'd1);
      gga_step  = tag_step(gga_prog_ff, 1'b0, rx_byte);
      rmc_step  = tag_step(rmc_prog_ff, 1'b1, rx_byte);

      snap.found = (gga_field_ff != 4'd0) && (rmc_field_ff != 3'd0);
      snap.lat   = (gga_field_ff == GGA_LAT) ? fin : lat_ff;
      snap.lon   = (gga_field_ff == GGA_LON) ? fin : lon_ff;
      snap.south = south_ff;
      snap.west  = west_ff;
      snap.alt   = alt_ff;
      snap.spd   = spd_ff;

      if (accept && !cmd) begin
         idle_in = 10'd0;
         if (count_ff < COUNT_W'(BUFFER_BYTES - 2)) begin
            count_in = COUNT_W'(count_ff + 1'b1);
            if (!ended_ff) begin
               if (rx_byte == nmea_pp_pkg::CH_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  if (gga_field_ff == 4'd0) begin
                     gga_prog_in = gga_step[2:0];
                     if (gga_step[3]) begin
                        gga_field_in = 4'd1;
                     end
                  end else if (gga_field_ff < GGA_END) begin
                     if (rx_byte == nmea_pp_pkg::CH_COMMA) begin
                        if (gga_field_ff == GGA_LAT) begin
                           lat_in = fin;
                        end else if (gga_field_ff == GGA_LON) begin
                           lon_in = fin;
                        end
                        gga_field_in = 4'(gga_field_ff + 4'd1);
                        tok_len_in   = 5'd0;
                        cand2_in     = CAND_CLEAR;
                        cand3_in     = CAND_CLEAR;
                     end else begin
                        if (gga_field_ff == GGA_LAT || gga_field_ff == GGA_LON) begin
                           if (tok_len_ff == DOT_POS) begin
                              dot4_in = (rx_byte == nmea_pp_pkg::CH_DOT);
                           end
                           if (tok_len_ff < 5'(KEEP_CHARS)) begin
                              if (tok_len_ff < 5'd2) begin
                                 cand2_in.deg = nmea_pp_pkg::acc_feed(cand2_ff.deg, rx_byte,
                                    nmea_pp_pkg::F_DEG, nmea_pp_pkg::DEG_CAP);
                              end else begin
                                 cand2_in.mins = nmea_pp_pkg::acc_feed(cand2_ff.mins, rx_byte,
                                    nmea_pp_pkg::F_MIN, nmea_pp_pkg::MIN_CAP);
                              end
                              if (tok_len_ff < 5'd3) begin
                                 cand3_in.deg = nmea_pp_pkg::acc_feed(cand3_ff.deg, rx_byte,
                                    nmea_pp_pkg::F_DEG, nmea_pp_pkg::DEG_CAP);
                              end else begin
                                 cand3_in.mins = nmea_pp_pkg::acc_feed(cand3_ff.mins, rx_byte,
                                    nmea_pp_pkg::F_MIN, nmea_pp_pkg::MIN_CAP);
                              end
                           end
                        end else if (gga_field_ff == GGA_NS) begin
                           if (tok_len_ff == 5'd0) begin
                              south_in = (rx_byte == nmea_pp_pkg::CH_S) ||
                                         (rx_byte == nmea_pp_pkg::CH_W);
                           end
                        end else if (gga_field_ff == GGA_EW) begin
                           if (tok_len_ff == 5'd0) begin
                              west_in = (rx_byte == nmea_pp_pkg::CH_S) ||
                                        (rx_byte == nmea_pp_pkg::CH_W);
                           end
                        end else if (gga_field_ff == GGA_ALT) begin
                           alt_in = nmea_pp_pkg::acc_feed(alt_ff, rx_byte,
                              nmea_pp_pkg::F_MM, nmea_pp_pkg::ALT_CAP);
                        end
                        if (tok_len_ff != LEN_MAX) begin
                           tok_len_in = 5'(tok_len_ff + 5'd1);
                        end
                     end
                  end

                  if (rmc_field_ff == 3'd0) begin
                     rmc_prog_in = rmc_step[2:0];
                     if (rmc_step[3]) begin
                        rmc_field_in = 3'd1;
                     end
                  end else if (rmc_field_ff < RMC_SPD) begin
                     if (rx_byte == nmea_pp_pkg::CH_COMMA) begin
                        rmc_field_in = 3'(rmc_field_ff + 3'd1);
                     end
                  end else begin
                     spd_in = nmea_pp_pkg::acc_feed(spd_ff, rx_byte,
                        nmea_pp_pkg::F_MM, nmea_pp_pkg::SPD_CAP);
                  end
               end
            end
         end
      end else if (accept && cmd) begin
         idle_in = idle_next;
         if (idle_next > gap_ff && count_ff != '0) begin
            emit         = 1'b1;
            count_in     = '0;
            ended_in     = 1'b0;
            gga_prog_in  = 3'd0;
            rmc_prog_in  = 3'd0;
            gga_field_in = 4'd0;
            rmc_field_in = 3'd0;
            tok_len_in   = 5'd0;
            cand2_in     = CAND_CLEAR;
            cand3_in     = CAND_CLEAR;
            lat_in       = nmea_pp_pkg::COORD_CLEAR;
            lon_in       = nmea_pp_pkg::COORD_CLEAR;
            south_in     = 1'b0;
            west_in      = 1'b0;
            alt_in       = nmea_pp_pkg::ACC_CLEAR;
            spd_in       = nmea_pp_pkg::ACC_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= nmea_pp_pkg::GAP_RESET;
         count_ff     <= '0;
         idle_ff      <= 10'd0;
         ended_ff     <= 1'b0;
         gga_prog_ff  <= 3'd0;
         rmc_prog_ff  <= 3'd0;
         gga_field_ff <= 4'd0;
         rmc_field_ff <= 3'd0;
         tok_len_ff   <= 5'd0;
         dot4_ff      <= 1'b0;
         cand2_ff     <= CAND_CLEAR;
         cand3_ff     <= CAND_CLEAR;
         lat_ff       <= nmea_pp_pkg::COORD_CLEAR;
         lon_ff       <= nmea_pp_pkg::COORD_CLEAR;
         south_ff     <= 1'b0;
         west_ff      <= 1'b0;
         alt_ff       <= nmea_pp_pkg::ACC_CLEAR;
         spd_ff       <= nmea_pp_pkg::ACC_CLEAR;
      end else begin
         gap_ff       <= gap_in;
         count_ff     <= count_in;
         idle_ff      <= idle_in;
         ended_ff     <= ended_in;
         gga_prog_ff  <= gga_prog_in;
         rmc_prog_ff  <= rmc_prog_in;
         gga_field_ff <= gga_field_in;
         rmc_field_ff <= rmc_field_in;
         tok_len_ff   <= tok_len_in;
         dot4_ff      <= dot4_in;
         cand2_ff     <= cand2_in;
         cand3_ff     <= cand3_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         south_ff     <= south_in;
         west_ff      <= west_in;
         alt_ff       <= alt_in;
         spd_ff       <= spd_in;
      end
   end

endmodule
`default_nettype wire

### rtl/nmea_pp_result.sv
`default_nettype none
module nmea_pp_result (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire nmea_pp_pkg::snap_type snap,
   output logic                      in_ready,
   input  wire logic                 out_ready,
   output logic                      out_valid,
   output nmea_pp_pkg::out_type      out_word
);

   localparam logic [30:0] RECIP_125 = 31'd1099511628;
   localparam logic [33:0] E7 = 34'd10000000;

   typedef struct packed {
      logic        zero;
      logic        dneg;
      logic        mneg;
      logic        hemi;
      logic [33:0] dp;
      logic [19:0] qhi;
      logic [1:0]  r;
      logic [19:0] ylo;
   } c1_type;

   typedef struct packed {
      logic               zero;
      logic               qneg;
      logic signed [40:0] sd;
      logic [39:0]        q;
   } c2_type;

   typedef struct packed {
      logic               found;
      c1_type             lat;
      c1_type             lon;
      logic signed [27:0] alt;
      logic [32:0]        spd_prod;
      logic               spd_neg;
   } s1_type;

   typedef struct packed {
      logic               found;
      c2_type             lat;
      c2_type             lon;
      logic signed [27:0] alt;
      logic [60:0]        spd_q;
      logic               spd_neg;
   } s2_type;

   logic                  v0_ff, v1_ff, v2_ff, v3_ff;
   logic                  rdy0, rdy1, rdy2, rdy3;
   nmea_pp_pkg::snap_type s0_ff;
   s1_type                s1_ff, s1_in;
   s2_type                s2_ff, s2_in;
   nmea_pp_pkg::out_type  s3_ff, s3_in;

   // Divide by three, one nibble a step; returns {quotient, remainder}.
   function automatic logic [21:0] div3_part(input logic [1:0] rin, input logic [19:0] y);
      logic [1:0]  r;
      logic [19:0] q;
      logic [5:0]  t;
      logic [13:0] p;
      logic [3:0]  qd;
      r = rin;
      q = '0;
      for (int i = 4; i >= 0; i--) begin
         t  = {r, y[i*4 +: 4]};
         p  = 14'(t) * 14'd171;
         qd = p[12:9];
         q[i*4 +: 4] = qd;
         r  = 2'(t - 6'(qd) * 6'd3);
      end
      return {q, r};
   endfunction

   function automatic c1_type mk_c1(input nmea_pp_pkg::coord_raw_type x, input logic hemi);
      c1_type      c;
      logic [39:0] y;
      logic [21:0] hi;
      y      = {1'b0, x.mins.mag[39:1]};
      hi     = div3_part(2'd0, y[39:20]);
      c.zero = x.zero;
      c.dneg = x.deg.neg;
      c.mneg = x.mins.neg;
      c.hemi = hemi;
      c.dp   = 34'(x.deg.mag[9:0]) * E7;
      c.qhi  = hi[21:2];
      c.r    = hi[1:0];
      c.ylo  = y[19:0];
      return c;
   endfunction

   function automatic c2_type mk_c2(input c1_type x);
      c2_type             c;
      logic [21:0]        lo;
      logic signed [40:0] dps;
      lo     = div3_part(x.r, x.ylo);
      dps    = $signed({7'd0, x.dp});
      c.zero = x.zero;
      c.qneg = x.mneg ^ x.hemi;
      c.sd   = (x.dneg ^ x.hemi) ? -dps : dps;
      c.q    = {x.qhi, lo[21:2]};
      return c;
   endfunction

   function automatic logic signed [34:0] fin_coord(input c2_type x);
      logic signed [40:0] qs;
      logic signed [40:0] v;
      qs = x.qneg ? -$signed({1'b0, x.q}) : $signed({1'b0, x.q});
      v  = x.zero ? 41'sd0 : 41'(x.sd + qs);
      if (v > nmea_pp_pkg::COORD_LIMIT) begin
         v = nmea_pp_pkg::COORD_LIMIT;
      end else if (v < -nmea_pp_pkg::COORD_LIMIT) begin
         v = -nmea_pp_pkg::COORD_LIMIT;
      end
      return v[34:0];
   endfunction

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign rdy0      = !v0_ff || rdy1;
   assign in_ready  = rdy0;
   assign out_valid = v3_ff;
   assign out_word  = s3_ff;

   always_comb begin
      s1_in.found    = s0_ff.found;
      s1_in.lat      = mk_c1(s0_ff.lat, s0_ff.south);
      s1_in.lon      = mk_c1(s0_ff.lon, s0_ff.west);
      s1_in.alt      = s0_ff.alt.neg ? -$signed(28'(s0_ff.alt.mag[26:0]))
                                     : $signed(28'(s0_ff.alt.mag[26:0]));
      s1_in.spd_prod = 33'(s0_ff.spd.mag[23:0]) * 33'd514;
      s1_in.spd_neg  = s0_ff.spd.neg;

      s2_in.found    = s1_ff.found;
      s2_in.lat      = mk_c2(s1_ff.lat);
      s2_in.lon      = mk_c2(s1_ff.lon);
      s2_in.alt      = s1_ff.alt;
      s2_in.spd_q    = 61'(s1_ff.spd_prod[32:3]) * 61'(RECIP_125);
      s2_in.spd_neg  = s1_ff.spd_neg;

      s3_in.found = s2_ff.found;
      s3_in.lat   = fin_coord(s2_ff.lat);
      s3_in.lon   = fin_coord(s2_ff.lon);
      s3_in.alt   = s2_ff.alt;
      s3_in.spd   = s2_ff.spd_neg ? -$signed(s2_ff.spd_q[60:37]) : $signed(s2_ff.spd_q[60:37]);
      if (!s2_ff.found) begin
         s3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) begin
            v0_ff <= load;
         end
         if (rdy1) begin
            v1_ff <= v0_ff;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
      if (rdy0 && load) begin
         s0_ff <= snap;
      end
      if (rdy1 && v0_ff) begin
         s1_ff <= s1_in;
      end
      if (rdy2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

endmodule
`default_nettype wire

### rtl/nmea_gga_rmc_position_parser.sv
// NMEA 0183 position parser: each input word is either a received character
// (tuser low) or a one millisecond tick (tuser high). Characters build a burst
// in which the first $GPGGA and $GPRMC sentences are decoded on the fly;
// once more than csr idle_gap ticks pass without a character, one result word
// carries latitude and longitude in degrees times 1e7, GGA altitude in mm and
// RMC speed in mm/s, all zero unless both sentences were seen. One word is
// taken every cycle while the pipeline has room; the result of the tick word
// that ends the burst goes through a four-stage pipeline set by the divide-by-three
// of the minutes and the reciprocal multiply that turns knots into mm/s. Input
// stalls only while that pipeline is full behind a stalled result.
`default_nettype none
`include "nmea_gga_rmc_position_parser_defines.svh"
module nmea_gga_rmc_position_parser #(
   parameter int BUFFER_BYTES = nmea_pp_pkg::BUFFER_BYTES_DEF,
   parameter int TOKEN_CHARS  = nmea_pp_pkg::TOKEN_CHARS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte
   input  wire logic         req_tuser,   // cmd
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // latitude_e7, longitude_e7, altitude_mm, speed_mm_s
   output logic              rsp_tuser,   // both_found
   input  wire logic         csr_wr_en,
   input  wire logic [9:0]   csr_wr_data
);

   logic                  accept;
   logic                  emit;
   logic                  lat_ok;
   nmea_pp_pkg::snap_type snap;
   nmea_pp_pkg::out_type  word;

   assign accept = req_tvalid && req_tready;

   nmea_pp_scanner #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .TOKEN_CHARS  (TOKEN_CHARS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_tuser),
      .rx_byte     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .emit        (emit),
      .snap        (snap)
   );

   nmea_pp_result u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .snap      (snap),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (word)
   );

   assign rsp_tuser = word.found;
   assign rsp_tdata = {6'd0, word.spd, word.alt, word.lon, word.lat};

   assign lat_ok = (word.lat <= nmea_pp_pkg::COORD_LIMIT) &&
                   (word.lat >= -nmea_pp_pkg::COORD_LIMIT);

   `NMEA_PP_CHECK(a_zero_when_missing, !(rsp_tvalid && !rsp_tuser) || rsp_tdata == '0)
   `NMEA_PP_CHECK(a_emit_has_room, !emit || req_tready)
   `NMEA_PP_CHECK(a_lat_in_range, !rsp_tvalid || lat_ok)
   `NMEA_PP_CHECK_NEXT(a_burst_cleared, emit, !emit)

endmodule
`default_nettype wire
